@@ rtl/core/audio_sample_ring_fifo_top_macros.svh @@
// assertion macros used by the checker file
`ifndef AUDIO_SAMPLE_RING_FIFO_TOP_MACROS_SVH
`define AUDIO_SAMPLE_RING_FIFO_TOP_MACROS_SVH

// clocked check, held off while reset is low
`define ASRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication check on a valid output word
`define ASRF_ASSERT_OUT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (o_out_valid |-> (cond))) else $error(msg);

`endif

@@ rtl/core/asrf_pkg.sv @@
// ----------------------------------------------------------------------------
// asrf_pkg
// Types and codes shared by the audio sample ring fifo modules.
// ----------------------------------------------------------------------------
`default_nettype none

package asrf_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam int LEN_W  = 12;
    localparam int SAMP_W = 16;

    typedef struct packed {
        logic                     op;
        logic signed [SAMP_W-1:0] sample_in;
        logic                     batch_first;
        logic [LEN_W-1:0]         batch_len;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMP_W-1:0] sample_out;
        logic                     accepted;
        logic                     underrun;
        logic                     block_done;
        logic [LEN_W-1:0]         free_space;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic take_in;
        logic finish_rd;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/core/asrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// asrf_ctrl
// Handshake and sequencing: accepts a word, and holds off for the memory
// read cycle that a pop needs.
// ----------------------------------------------------------------------------
`default_nettype none

module asrf_ctrl import asrf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_op,
    input  wire        i_out_stall,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic take;

    // output slot must be free or emptying this cycle
    assign o_in_stall = (r_state != ST_IDLE) || (i_status.out_full && i_out_stall);
    assign take       = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && (i_in_op == OP_POP)) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.take_in   = take;
    assign o_cmd.finish_rd = (r_state == ST_READ);

endmodule

`default_nettype wire

@@ rtl/core/asrf_dpath.sv @@
// ----------------------------------------------------------------------------
// asrf_dpath
// Sample ring, pointers, fill count, batch check, block counter and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asrf_dpath import asrf_pkg::*; #(
    parameter int RING_DEPTH = 2048,
    parameter int BLOCK_LEN  = 2048
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_word   i_in_data,
    input  wire        i_out_stall,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_word  o_out_data
);

    localparam int PW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int BW   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int FW   = (CW > LEN_W) ? CW : LEN_W;

    logic signed [SAMP_W-1:0] mem [RING_DEPTH];

    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_fill, n_fill;
    logic [BW-1:0]  r_blk_pos, n_blk_pos;
    logic           r_dropping, n_dropping;
    logic           r_out_valid, n_out_valid;
    t_out_word      r_out, n_out;
    t_out_word      r_pend, n_pend;
    logic signed [SAMP_W-1:0] r_rd_data;

    logic           is_pop;
    logic           wr_en;
    logic           rd_en;
    logic [CW-1:0]  free_now;
    logic [FW-1:0]  free_ext;
    logic           drop;
    logic           done;

    assign is_pop   = (i_in_data.op == OP_POP);
    assign free_now = CW'(RING_DEPTH) - r_fill;

    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_fill     = r_fill;
        n_blk_pos  = r_blk_pos;
        n_dropping = r_dropping;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        drop       = r_dropping;
        done       = 1'b0;
        n_pend     = r_pend;

        if (i_cmd.take_in) begin
            if (!is_pop) begin
                // first word of a batch re-runs the space check
                if (i_in_data.batch_first) begin
                    drop = FW'(i_in_data.batch_len) > FW'(free_now);
                end
                n_dropping = drop;
                if (!drop && (r_fill != CW'(RING_DEPTH))) begin
                    wr_en    = 1'b1;
                    n_fill   = r_fill + CW'(1);
                    n_wr_ptr = (r_wr_ptr == PW'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
                end
            end else begin
                if (r_fill != '0) begin
                    rd_en    = 1'b1;
                    n_fill   = r_fill - CW'(1);
                    n_rd_ptr = (r_rd_ptr == PW'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
                end
                // underrun still counts, the block is zero-filled
                done      = (r_blk_pos == BW'(BLOCK_LEN - 1));
                n_blk_pos = done ? '0 : r_blk_pos + BW'(1);
            end
        end

        free_ext = FW'(CW'(RING_DEPTH) - n_fill);

        n_out            = r_out;
        n_out.sample_out = '0;
        n_out.accepted   = wr_en;
        n_out.underrun   = is_pop && !rd_en;
        n_out.block_done = done;
        n_out.free_space = free_ext[LEN_W-1:0];
        if (i_cmd.take_in && is_pop) begin
            n_pend = n_out;
        end

        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.take_in && !is_pop) begin
            n_out_valid = 1'b1;
        end else if (i_cmd.finish_rd) begin
            n_out_valid = 1'b1;
            n_out       = r_pend;
            n_out.sample_out = r_pend.underrun ? '0 : r_rd_data;
        end else begin
            n_out = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wr_ptr] <= i_in_data.sample_in;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_blk_pos   <= '0;
            r_dropping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_blk_pos   <= n_blk_pos;
            r_dropping  <= n_dropping;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

`default_nettype wire

@@ rtl/core/audio_sample_ring_fifo_top.sv @@
// ----------------------------------------------------------------------------
// audio_sample_ring_fifo_top
// Ring fifo of signed 16-bit audio samples with batch admission and
// block-wise drain.
// ----------------------------------------------------------------------------
// A push word is answered in the cycle after it is accepted. A pop reads the
// sample ring, a memory whose read data is registered, and its result passes
// to the output register. The next word is taken once the previous result is
// in the output register, so pushes run at one word per cycle while the output
// side does not stall, and a pop holds off the next word until its read is
// done. The ring needs no clearing pass after reset: an entry is only read
// after it has been written. A batch whose declared length exceeds the free
// space is dropped whole; every result carries the free space after the word.
`default_nettype none

module audio_sample_ring_fifo_top import asrf_pkg::*; #(
    parameter int RING_DEPTH = 2048,
    parameter int BLOCK_LEN  = 2048
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_word o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    asrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_data.op),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    asrf_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .BLOCK_LEN  (BLOCK_LEN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/asrf_checker.sv @@
// ----------------------------------------------------------------------------
// asrf_checker
// Port-level checks on the result channel of the ring fifo.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_sample_ring_fifo_top_macros.svh"

module asrf_checker import asrf_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_stall,
    input wire       o_out_valid,
    input t_out_word o_out_data
);

    `ASRF_ASSERT(a_out_hold, (o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data)), "stalled result word changed")
    `ASRF_ASSERT_OUT(a_underrun_zero, (!o_out_data.underrun || (o_out_data.sample_out == '0)), "underrun word carries a sample")
    `ASRF_ASSERT_OUT(a_push_flags, (!o_out_data.accepted || (!o_out_data.underrun && !o_out_data.block_done)), "stored push word carries pop flags")
    `ASRF_ASSERT_OUT(a_push_no_sample, (!o_out_data.accepted || (o_out_data.sample_out == '0)), "push word carries a sample")

endmodule

bind audio_sample_ring_fifo_top asrf_checker u_asrf_checker (.*);

`default_nettype wire
